FILE: hw/rtl/ffbta_pkg.sv
// Shared types, codes and constants of the first-fit block table allocator.
`default_nettype none

package ffbta_pkg;

    // Field widths
    localparam int WORD_W = 24;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Defaults
    localparam int                DEFAULT_TABLE_ENTRIES = 64;
    localparam logic [WORD_W-1:0] RESET_MEMORY_SIZE     = 24'd1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_FIT    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FREED     = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_FORMATTED = 2'd3;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic              taken;
        logic [WORD_W-1:0] length;
        logic [WORD_W-1:0] start;
    } entry_t;

    // Kind of pass over the table
    typedef enum logic [1:0] {
        PASS_CLEAR,
        PASS_ALLOC,
        PASS_FREE
    } pass_mode_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_INIT_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WR_FIT,
        ST_WR_ZERO,
        ST_FMT_CLR,
        ST_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              capture;
        logic              pass_start;
        pass_mode_t        pass_mode;
        logic              use_reset_len;
        logic              write_fit;
        logic              write_zero;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
    } ffbta_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pass_done;
        logic fit_found;
        logic zero_found;
        logic out_busy;
    } ffbta_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffbta_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ffbta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ffbta_datapath.sv
// Datapath: table RAM, pass sequencing, fit search, write-back and result register.
`default_nettype none

module ffbta_datapath import ffbta_pkg::*; #(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr,
    input  wire logic [WORD_W-1:0] cfg_data,
    input  wire logic [WORD_W-1:0] s_amount,
    input  wire logic [WORD_W-1:0] s_start_req,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic      [STAT_W-1:0] m_status,
    output logic      [WORD_W-1:0] m_block_start,
    input  wire ffbta_cmd_t        cmd,
    output ffbta_stat_t            stat
);

    localparam int               IDX_W    = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [WORD_W-1:0] memory_size_reg, memory_size_next;
    logic [WORD_W-1:0] fmt_len_reg, fmt_len_next;
    logic [WORD_W-1:0] amount_reg, amount_next;
    logic [WORD_W-1:0] start_req_reg, start_req_next;
    pass_mode_t        mode_reg, mode_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              issue_reg, issue_next;
    logic              clr_reg, clr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              fit_found_reg, fit_found_next;
    logic [IDX_W-1:0]  fit_idx_reg, fit_idx_next;
    logic [WORD_W-1:0] fit_start_reg, fit_start_next;
    logic [WORD_W-1:0] fit_len_reg, fit_len_next;
    logic              zero_found_reg, zero_found_next;
    logic [IDX_W-1:0]  zero_idx_reg, zero_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [WORD_W-1:0] m_block_start_reg, m_block_start_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wentry;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t               rd_entry;

    ffbta_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .re   (issue_reg),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Sequence passes, capture requests, track first fit and first empty slot
    always_comb begin
        memory_size_next   = memory_size_reg;
        fmt_len_next       = fmt_len_reg;
        amount_next        = amount_reg;
        start_req_next     = start_req_reg;
        mode_next          = mode_reg;
        idx_next           = idx_reg;
        issue_next         = issue_reg;
        clr_next           = clr_reg;
        rd_vld_next        = issue_reg;
        rd_idx_next        = idx_reg;
        fit_found_next     = fit_found_reg;
        fit_idx_next       = fit_idx_reg;
        fit_start_next     = fit_start_reg;
        fit_len_next       = fit_len_reg;
        zero_found_next    = zero_found_reg;
        zero_idx_next      = zero_idx_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_block_start_next = m_block_start_reg;

        if (cfg_wr) begin
            memory_size_next = cfg_data;
        end

        if (cmd.capture) begin
            amount_next    = s_amount;
            start_req_next = s_start_req;
        end

        if (cmd.pass_start) begin
            mode_next       = cmd.pass_mode;
            idx_next        = '0;
            clr_next        = (cmd.pass_mode == PASS_CLEAR);
            issue_next      = (cmd.pass_mode != PASS_CLEAR);
            fit_found_next  = 1'b0;
            zero_found_next = 1'b0;
            if (cmd.pass_mode == PASS_CLEAR) begin
                fmt_len_next = cmd.use_reset_len ? RESET_MEMORY_SIZE : memory_size_reg;
            end
        end else if (clr_reg || issue_reg) begin
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg == LAST_IDX) begin
                clr_next   = 1'b0;
                issue_next = 1'b0;
            end
        end

        // Evaluate the entry read in the previous cycle
        if (rd_vld_reg && mode_reg == PASS_ALLOC) begin
            if (!fit_found_reg && !rd_entry.taken && amount_reg != '0 &&
                rd_entry.length >= amount_reg) begin
                fit_found_next = 1'b1;
                fit_idx_next   = rd_idx_reg;
                fit_start_next = rd_entry.start;
                fit_len_next   = rd_entry.length;
            end
            if (!zero_found_reg && rd_entry.length == '0) begin
                zero_found_next = 1'b1;
                zero_idx_next   = rd_idx_reg;
            end
        end

        // Result register: load a new transaction, drop it once taken
        if (cmd.out_load) begin
            m_valid_next       = 1'b1;
            m_status_next      = cmd.out_status;
            m_block_start_next = (cmd.out_status == STATUS_ALLOCATED) ? fit_start_reg : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Select the one table write of this cycle
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wentry = '0;
        if (clr_reg) begin
            ram_we            = 1'b1;
            ram_wentry.length = (idx_reg == '0) ? fmt_len_reg : '0;
        end else if (rd_vld_reg && mode_reg == PASS_FREE &&
                     rd_entry.start == start_req_reg) begin
            ram_we           = 1'b1;
            ram_waddr        = rd_idx_reg;
            ram_wentry       = rd_entry;
            ram_wentry.taken = 1'b0;
        end else if (cmd.write_fit) begin
            ram_we            = 1'b1;
            ram_waddr         = fit_idx_reg;
            ram_wentry.taken  = 1'b1;
            ram_wentry.length = amount_reg;
            ram_wentry.start  = fit_start_reg;
        end else if (cmd.write_zero) begin
            ram_we            = 1'b1;
            ram_waddr         = zero_idx_reg;
            ram_wentry.length = fit_len_reg - amount_reg;
            ram_wentry.start  = fit_start_reg + amount_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_size_reg <= RESET_MEMORY_SIZE;
            mode_reg        <= PASS_CLEAR;
            idx_reg         <= '0;
            issue_reg       <= 1'b0;
            clr_reg         <= 1'b0;
            rd_vld_reg      <= 1'b0;
            fit_found_reg   <= 1'b0;
            zero_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            memory_size_reg <= memory_size_next;
            mode_reg        <= mode_next;
            idx_reg         <= idx_next;
            issue_reg       <= issue_next;
            clr_reg         <= clr_next;
            rd_vld_reg      <= rd_vld_next;
            fit_found_reg   <= fit_found_next;
            zero_found_reg  <= zero_found_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        fmt_len_reg       <= fmt_len_next;
        amount_reg        <= amount_next;
        start_req_reg     <= start_req_next;
        rd_idx_reg        <= rd_idx_next;
        fit_idx_reg       <= fit_idx_next;
        fit_start_reg     <= fit_start_next;
        fit_len_reg       <= fit_len_next;
        zero_idx_reg      <= zero_idx_next;
        m_status_reg      <= m_status_next;
        m_block_start_reg <= m_block_start_next;
    end

    assign stat.pass_done  = (clr_reg && idx_reg == LAST_IDX) ||
                             (rd_vld_reg && rd_idx_reg == LAST_IDX);
    assign stat.fit_found  = fit_found_reg;
    assign stat.zero_found = zero_found_reg;
    assign stat.out_busy   = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_block_start = m_block_start_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ffbta_ctrl.sv
// Controller state machine: sequences clear, scan and write-back steps per request.
`default_nettype none

module ffbta_ctrl import ffbta_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [OP_W-1:0] s_operation,
    input  wire ffbta_stat_t     stat,
    output ffbta_cmd_t           cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [STAT_W-1:0] result_reg, result_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        result_reg <= result_next;
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        result_next = result_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.pass_mode  = PASS_CLEAR;
        cmd.out_status = result_reg;

        case (state_reg)
            ST_INIT: begin
                cmd.pass_start    = 1'b1;
                cmd.use_reset_len = 1'b1;
                state_next        = ST_INIT_CLR;
            end
            ST_INIT_CLR: begin
                if (stat.pass_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    op_next     = s_operation;
                    case (s_operation)
                        OP_ALLOC: begin
                            cmd.pass_start = 1'b1;
                            cmd.pass_mode  = PASS_ALLOC;
                            state_next     = ST_SCAN;
                        end
                        OP_FREE: begin
                            cmd.pass_start = 1'b1;
                            cmd.pass_mode  = PASS_FREE;
                            state_next     = ST_SCAN;
                        end
                        OP_FORMAT: begin
                            cmd.pass_start = 1'b1;
                            cmd.pass_mode  = PASS_CLEAR;
                            state_next     = ST_FMT_CLR;
                        end
                        default: begin
                            result_next = STATUS_NO_FIT;
                            state_next  = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (stat.pass_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (op_reg == OP_FREE) begin
                    result_next = STATUS_FREED;
                    state_next  = ST_FINISH;
                end else if (stat.fit_found) begin
                    result_next = STATUS_ALLOCATED;
                    state_next  = ST_WR_FIT;
                end else begin
                    result_next = STATUS_NO_FIT;
                    state_next  = ST_FINISH;
                end
            end
            ST_WR_FIT: begin
                cmd.write_fit = 1'b1;
                state_next    = stat.zero_found ? ST_WR_ZERO : ST_FINISH;
            end
            ST_WR_ZERO: begin
                cmd.write_zero = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FMT_CLR: begin
                if (stat.pass_done) begin
                    result_next = STATUS_FORMATTED;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/first_fit_block_table_allocator.sv
// Top level of the first-fit block table allocator.
//
// Channels: s_* takes one request transaction (operation, amount, start_req);
// m_* returns exactly one result transaction (status, block_start) per request.
// cfg_* writes memory_size; cfg_ready is always high. Write it only while idle.
// Steps, with N = TABLE_ENTRIES: allocate makes one full read pass over the
// table RAM, then up to two write-backs; free makes one read-modify-write pass;
// format makes one write sweep; an unused operation code goes straight to the
// finish state. One request is in work at a time: the block takes no new request
// before it is through with the last one; the sequential table pass visits one
// entry per cycle. A new request is taken as soon as the controller is back in
// idle, even while the previous result still waits in the output register.
// Reset: a setup state, then the table RAM is cleared by a sweep over all N
// entries (entry 0 gets 1024 bytes) during which s_ready is low; configuration
// writes are taken meanwhile.
// Stall: when m_ready is low the result holds; a finished request then waits
// in the controller until the output register frees up.
`default_nettype none

module first_fit_block_table_allocator import ffbta_pkg::*; #(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [WORD_W-1:0] cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_operation,
    input  wire logic [WORD_W-1:0] s_amount,
    input  wire logic [WORD_W-1:0] s_start_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [STAT_W-1:0] m_status,
    output logic      [WORD_W-1:0] m_block_start
);

    ffbta_cmd_t  cmd;
    ffbta_stat_t stat;

    assign cfg_ready = 1'b1;

    ffbta_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .stat       (stat),
        .cmd        (cmd)
    );

    ffbta_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .s_amount     (s_amount),
        .s_start_req  (s_start_req),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_status     (m_status),
        .m_block_start(m_block_start),
        .cmd          (cmd),
        .stat         (stat)
    );

    // An accepted request keeps the block busy for at least the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one still in work");

    // Never load a result over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid && !m_ready))
        else $error("result register overwritten");

    // Only a successful allocate reports a nonzero start
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_ALLOCATED |-> m_block_start == '0)
        else $error("block_start nonzero on a non-allocate result");

    // No request is taken right after reset: the clearing sweep runs first
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request accepted before table clear");

endmodule

`default_nettype wire
